@@ rtl/lila_pkg.sv @@
// Shared constants and types for the lowest-index lease allocator.
package lila_pkg;

  localparam int MAX_SERVERS = 128;
  localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int CFG_W       = 8;
  localparam int NEED_W      = 8;
  localparam int DUR_W       = 10;
  localparam int SUM_W       = 14;
  localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0] SERVER_COUNT_RST = CFG_W'(128);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } lila_state_e;

  // Command broadcast to every cell of the ring; at most one bit is set.
  typedef struct packed {
    logic tick;
    logic shift;
    logic commit;
    logic clear;
  } lila_op_t;

endpackage

@@ rtl/lila_cell.sv @@
// One server cell: busy counter and tentative-grant mark, shifting along the ring.
module lila_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lila_pkg::lila_op_t        op_i,
  input  logic [lila_pkg::DUR_W-1:0] dur_i,
  input  logic [lila_pkg::DUR_W-1:0] nxt_cnt_i,
  input  logic                      nxt_mark_i,
  output logic [lila_pkg::DUR_W-1:0] cnt_o,
  output logic                      mark_o
);
  import lila_pkg::*;

  logic [DUR_W-1:0] cnt_q, cnt_d;
  logic             mark_q, mark_d;

  always_comb begin
    cnt_d  = cnt_q;
    mark_d = mark_q;
    priority if (op_i.tick) begin
      if (cnt_q != '0) cnt_d = cnt_q - DUR_W'(1);
    end else if (op_i.shift) begin
      cnt_d  = nxt_cnt_i;
      mark_d = nxt_mark_i;
    end else if (op_i.commit) begin
      if (mark_q) cnt_d = dur_i;
      mark_d = 1'b0;
    end else if (op_i.clear) begin
      mark_d = 1'b0;
    end else begin
      cnt_d  = cnt_q;
      mark_d = mark_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mark_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
    end
  end

  assign cnt_o  = cnt_q;
  assign mark_o = mark_q;

endmodule

@@ rtl/lila_ctrl.sv @@
// Sequencer: takes requests, scans the ring head, and holds the result register.
module lila_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lila_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_action_i,
  input  logic [lila_pkg::NEED_W-1:0] in_needed_i,
  input  logic [lila_pkg::DUR_W-1:0]  in_dur_i,
  input  logic [lila_pkg::DUR_W-1:0]  head_cnt_i,
  input  logic                        head_mark_i,
  output logic                        tail_mark_o,
  output lila_pkg::lila_op_t          op_o,
  output logic [lila_pkg::DUR_W-1:0]  dur_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_granted_o,
  output logic [lila_pkg::SUM_W-1:0]  out_sum_o
);
  import lila_pkg::*;

  lila_state_e      state_q, state_d;
  logic [CFG_W-1:0] server_count_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [NEED_W-1:0] left_q, left_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [DUR_W-1:0] dur_q;
  logic [CMP_W-1:0] count_eff;
  logic             accept, take, fin_go, granted;
  logic             out_valid_q, out_granted_q;
  logic [SUM_W-1:0] out_sum_q;

  assign count_eff = (CMP_W'(server_count_q) > CMP_W'(MAX_SERVERS)) ?
                     CMP_W'(MAX_SERVERS) : CMP_W'(server_count_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // Only cells inside the pool and still free are taken, lowest index first.
  assign take       = (state_q == ST_SCAN) && (CMP_W'(idx_q) < count_eff) &&
                      (head_cnt_i == '0) && (left_q != '0);
  assign fin_go     = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign granted    = (left_q == '0);

  assign tail_mark_o = head_mark_i | take;
  assign dur_o       = dur_q;

  always_comb begin
    op_o.tick   = accept && !in_action_i;
    op_o.shift  = (state_q == ST_SCAN);
    op_o.commit = fin_go && granted;
    op_o.clear  = fin_go && !granted;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    left_d  = left_q;
    sum_d   = sum_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_action_i) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          left_d  = in_needed_i;
          sum_d   = '0;
        end
      end
      ST_SCAN: begin
        if (take) begin
          left_d = left_q - NEED_W'(1);
          sum_d  = sum_q + SUM_W'(idx_q) + SUM_W'(1);
        end
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(MAX_SERVERS - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      server_count_q <= SERVER_COUNT_RST;
      idx_q          <= '0;
      left_q         <= '0;
      sum_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      if (cfg_we_i) server_count_q <= cfg_wdata_i;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_action_i) dur_q <= in_dur_i;
    if (fin_go) begin
      out_granted_q <= granted;
      out_sum_q     <= granted ? sum_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_granted_o = out_granted_q;
  assign out_sum_o     = out_sum_q;

`ifndef SYNTHESIS
  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !accept) |=> (state_q != ST_SCAN || idx_q == '0))
    else $error("scan did not start at the ring head");
  a_head_unmarked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !head_mark_i)
    else $error("marked cell reached the head during a scan");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> (state_q == ST_IDLE && out_valid_q))
    else $error("finish did not post a result");
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_granted_q) |-> (out_sum_q == '0))
    else $error("refused request carries a nonzero sum");
`endif

endmodule

@@ rtl/lowest_index_lease_allocator_top.sv @@
// Top level: request sequencer plus a ring of server cells.
// A tick request updates every cell at once; it gives no result.
// An allocation request rotates the ring once (one cell past the head per cycle), then
// commits from the finish state, which registers its result; the next request is taken
// once the sequencer is back in idle. An unread result holds the commit.
// Reset clears all busy counters (every server free) and sets server_count to 128.
module lowest_index_lease_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] servers_needed, [17:8] lease_duration, rest zero
  input  logic        s_axis_tuser,  // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [13:0] server_number_sum, rest zero
  output logic        m_axis_tuser   // [0] granted
);
  import lila_pkg::*;

  logic [DUR_W-1:0] cnt_w [MAX_SERVERS];
  logic             mark_w [MAX_SERVERS];
  logic             tail_mark;
  logic [DUR_W-1:0] dur;
  lila_op_t         op;
  logic [SUM_W-1:0] out_sum;

  lila_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_needed_i   (s_axis_tdata[7:0]),
    .in_dur_i      (s_axis_tdata[17:8]),
    .head_cnt_i    (cnt_w[0]),
    .head_mark_i   (mark_w[0]),
    .tail_mark_o   (tail_mark),
    .op_o          (op),
    .dur_o         (dur),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_granted_o (m_axis_tuser),
    .out_sum_o     (out_sum)
  );

  // Each cell takes its upper neighbor's contents on a shift; the head wraps to the tail.
  for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
    if (i == MAX_SERVERS - 1) begin : g_tail
      lila_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .op_i       (op),
        .dur_i      (dur),
        .nxt_cnt_i  (cnt_w[0]),
        .nxt_mark_i (tail_mark),
        .cnt_o      (cnt_w[i]),
        .mark_o     (mark_w[i])
      );
    end else begin : g_body
      lila_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .op_i       (op),
        .dur_i      (dur),
        .nxt_cnt_i  (cnt_w[i+1]),
        .nxt_mark_i (mark_w[i+1]),
        .cnt_o      (cnt_w[i]),
        .mark_o     (mark_w[i])
      );
    end
  end

  assign m_axis_tdata = {2'b00, out_sum};

endmodule

@@ tb/sv/lowest_index_lease_allocator_top_tb.sv @@
// Self-checking testbench for the lowest-index lease allocator.
module lowest_index_lease_allocator_top_tb;
  import lila_pkg::*;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;
  localparam int   STALL_LIMIT = 5000;
  localparam int   DRAIN_CYCLES = 200;
  localparam int   PHASE_ITEMS = 200;

  typedef struct packed {
    logic             granted;
    logic [SUM_W-1:0] sum;
  } lease_result_t;

  class lease_scoreboard;
    logic [DUR_W-1:0] busy_left [MAX_SERVERS];
    logic [CFG_W-1:0] pool_size;
    lease_result_t    grant_q[$];
    int               errors;

    function new();
      foreach (busy_left[i]) busy_left[i] = '0;
      pool_size = SERVER_COUNT_RST;
      errors    = 0;
    endfunction

    function void set_pool_size(logic [CFG_W-1:0] v);
      pool_size = v;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function int active_count();
      return (pool_size > MAX_SERVERS) ? MAX_SERVERS : int'(pool_size);
    endfunction

    // Works out the outcome of one accepted request and updates the pool.
    function void note_request(logic action, logic [NEED_W-1:0] need,
                               logic [DUR_W-1:0] dur);
      int            active;
      int            free_cnt;
      int            left;
      int            total;
      lease_result_t r;
      if (action == ACT_TICK) begin
        foreach (busy_left[i]) if (busy_left[i] != '0) busy_left[i] = busy_left[i] - 1'b1;
        return;
      end
      active   = active_count();
      free_cnt = 0;
      for (int i = 0; i < active; i++) if (busy_left[i] == '0) free_cnt++;
      if (free_cnt < int'(need)) begin
        r.granted = 1'b0;
        r.sum     = '0;
      end else begin
        left  = int'(need);
        total = 0;
        for (int i = 0; i < active && left > 0; i++) begin
          if (busy_left[i] == '0) begin
            busy_left[i] = dur;
            total += i + 1;
            left--;
          end
        end
        r.granted = 1'b1;
        r.sum     = total[SUM_W-1:0];
      end
      grant_q.push_back(r);
    endfunction

    function void log_mismatch(string what, lease_result_t want, lease_result_t got);
      errors++;
      if (errors <= 10)
        $display("mismatch (%s): expected granted=%0d sum=%0d, got granted=%0d sum=%0d",
                 what, want.granted, want.sum, got.granted, got.sum);
    endfunction

    function void check_result(logic granted, logic [SUM_W-1:0] sum);
      lease_result_t want;
      lease_result_t got;
      got.granted = granted;
      got.sum     = sum;
      if (grant_q.size() == 0) begin
        log_mismatch("unexpected result", '0, got);
        return;
      end
      want = grant_q.pop_front();
      if (want.granted !== got.granted || want.sum !== got.sum)
        log_mismatch("field", want, got);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] servers_needed, [17:8] lease_duration
  logic        s_axis_tuser = 1'b0;  // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // [13:0] server_number_sum
  logic        m_axis_tuser;  // [0] granted

  lease_scoreboard sb = new();
  int send_idle = 21;
  int recv_idle = 79;
  int sent = 0;
  int stall_cnt = 0;
  logic [7:0] phase_counts [7] = '{8'd1, 8'd0, 8'd255, 8'd5, 8'd129, 8'd64, 8'd128};

  always #4 clk_i = ~clk_i;

  lowest_index_lease_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Result side: check, throttle and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[SUM_W-1:0]);
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) || cfg_we_i)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic action, input logic [NEED_W-1:0] need,
                           input logic [DUR_W-1:0] dur);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {6'b0, dur, need};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(action, need, dur);
    sent++;
    if (sent >= 1080) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (sent >= 540) begin
      send_idle = 79;
      recv_idle = 21;
    end
  endtask

  // The register is only written once every result is in and the block has settled.
  task automatic write_pool_size(input logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_pool_size(v);
  endtask

  task automatic send_random(input int n);
    logic [NEED_W-1:0] need;
    logic [DUR_W-1:0]  dur;
    int                active;
    int                pick;
    for (int k = 0; k < n; k++) begin
      active = sb.active_count();
      pick = $urandom_range(99);
      if (pick < 70)      need = NEED_W'($urandom_range(8, 1));
      else if (pick < 80) need = '0;
      else if (pick < 90) need = NEED_W'($urandom_range(255, 0));
      else                need = NEED_W'($urandom_range((active + 2 > 255) ? 255 : active + 2,
                                                        (active > 2) ? active - 2 : 0));
      pick = $urandom_range(99);
      if (pick < 76)      dur = DUR_W'($urandom_range(12, 1));
      else if (pick < 86) dur = '0;
      else if (pick < 96) dur = DUR_W'($urandom_range(60, 13));
      else                dur = DUR_W'($urandom_range(1023, 0));
      send_item(($urandom_range(99) < 45) ? ACT_TICK : ACT_ALLOC, need, dur);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero need, zero duration, the whole pool, refusals and the widest fields.
    send_item(ACT_ALLOC, 8'd0,   10'd5);
    send_item(ACT_ALLOC, 8'd1,   10'd0);
    send_item(ACT_ALLOC, 8'd128, 10'd2);
    send_item(ACT_ALLOC, 8'd1,   10'd5);
    send_item(ACT_ALLOC, 8'd255, 10'd1023);
    send_item(ACT_TICK,  8'd0,   10'd0);
    send_item(ACT_TICK,  8'd255, 10'd1023);
    send_item(ACT_ALLOC, 8'd126, 10'd1);
    // The two long leases land on the top servers so small pools stay usable.
    send_item(ACT_ALLOC, 8'd1,   10'd1023);
    send_item(ACT_ALLOC, 8'd1,   10'd512);
    send_item(ACT_ALLOC, 8'd1,   10'd1);
    send_item(ACT_TICK,  8'd0,   10'd0);
    send_item(ACT_ALLOC, 8'd127, 10'd3);
    send_item(ACT_ALLOC, 8'd126, 10'd0);
    send_item(ACT_ALLOC, 8'd129, 10'd1);
    send_random(PHASE_ITEMS);

    foreach (phase_counts[p]) begin
      write_pool_size(phase_counts[p]);
      send_random(PHASE_ITEMS);
    end
    write_pool_size(CFG_W'($urandom_range(128, 1)));
    send_random(PHASE_ITEMS / 2);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
